// ----- rtl/core/ppd_pkg.sv -----
package ppd_pkg;

    // field and intermediate widths
    localparam int VTX_W  = 32;   // vertex / query coordinate
    localparam int DIFF_W = 33;   // coordinate difference
    localparam int MAG_W  = 32;   // magnitude of a difference
    localparam int PRD_W  = 64;   // one 32x32 partial product
    localparam int LSQ_W  = 65;   // squared edge length, squared vector length
    localparam int DOT_W  = 66;   // signed dot / cross product
    localparam int CR2_W  = 130;  // squared cross product
    localparam int QUO_W  = 65;   // cross^2 / length^2
    localparam int RAD_W  = 66;   // square root radicand
    localparam int ROOT_W = 33;   // square root result
    localparam int DST_W  = 32;   // distance field
    localparam int SW_W   = 31;   // stroke width register

    // configuration register indexes
    localparam logic [1:0] REG_QUERY_X      = 2'd0;
    localparam logic [1:0] REG_QUERY_Y      = 2'd1;
    localparam logic [1:0] REG_STROKE_WIDTH = 2'd2;

    typedef logic [4:0] op_t;

    localparam op_t OP_NOP         = 5'd0;
    localparam op_t OP_LOAD        = 5'd1;
    localparam op_t OP_SETUP_OPEN  = 5'd2;
    localparam op_t OP_SETUP_CLOSE = 5'd3;
    localparam op_t OP_LEN_X       = 5'd4;
    localparam op_t OP_LEN_Y       = 5'd5;
    localparam op_t OP_DOT_X       = 5'd6;
    localparam op_t OP_DOT_Y       = 5'd7;
    localparam op_t OP_CRS_A       = 5'd8;
    localparam op_t OP_CRS_B       = 5'd9;
    localparam op_t OP_W2_X        = 5'd10;
    localparam op_t OP_W2_Y        = 5'd11;
    localparam op_t OP_W3_X        = 5'd12;
    localparam op_t OP_W3_Y        = 5'd13;
    localparam op_t OP_CR2_LO      = 5'd14;
    localparam op_t OP_CR2_MID     = 5'd15;
    localparam op_t OP_CR2_TOP     = 5'd16;
    localparam op_t OP_CR2_HI      = 5'd17;
    localparam op_t OP_DIV         = 5'd18;
    localparam op_t OP_SQRT_W      = 5'd19;
    localparam op_t OP_SQRT_P      = 5'd20;
    localparam op_t OP_LEN_DONE    = 5'd21;
    localparam op_t OP_LEN_SAT     = 5'd22;
    localparam op_t OP_PERP_DONE   = 5'd23;
    localparam op_t OP_UPDATE      = 5'd24;
    localparam op_t OP_EMIT        = 5'd25;

    typedef struct packed {
        logic have_first;  // first vertex of polygon captured
        logic last;        // current vertex closes the polygon
        logic busy;        // divider or root unit running
        logic degen;       // squared edge length at or below epsilon
        logic pre_start;   // projection before edge start
        logic past;        // projection past edge end
        logic sq_ovf;      // squared vector length at or above 2^64
        logic out_free;    // output register can take a word
    } dp_status_t;

endpackage

// ----- rtl/core/polygon_point_distance.sv -----
// channel  | ports                      | contents
// ---------+----------------------------+-------------------------------------
// s_       | s_tvalid s_tready s_tdata  | one polygon vertex, s_tlast on last
// m_       | m_tvalid m_tready m_tdata  | distance, m_tuser = inside flag
// cfg_     | cfg_wr_en cfg_index        | query_x, query_y, stroke_width
//
// A vertex is taken only while idle; a polygon's first vertex goes to a check state
// instead of an edge. Each edge: setup and products on the shared 32x32 multiplier,
// then the 33-step root when the nearest point is an endpoint (skipped if the square
// saturates), or the 65-step divider, then the 33-step root, when it lies on the edge.
// A vertex marked last runs its own edge and the closing one, then the emit state.
// Reset needs no clearing pass; the next vertex is taken while a result waits in the
// output register, and only the next result stalls on m_tready.
module polygon_point_distance
    import ppd_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // vertex_x [31:0], vertex_y [63:32]
    input  logic        s_tlast,    // last_vertex
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // distance [31:0]
    output logic        m_tuser,    // inside_res
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    op_t        op;
    dp_status_t status;

    ppd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .op       (op)
    );

    ppd_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .op         (op),
        .status     (status),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_distance (m_tdata),
        .m_inside   (m_tuser)
    );

endmodule

// ----- rtl/core/ppd_div.sv -----
module ppd_div
    import ppd_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [CR2_W-1:0] dividend,
    input  logic [LSQ_W-1:0] divisor,
    output logic             busy,
    output logic [QUO_W-1:0] quot
);

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [LSQ_W-1:0] rem_reg;
    logic [QUO_W-1:0] dvd_reg;
    logic [LSQ_W-1:0] dsr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic [LSQ_W:0]   trial;
    logic             fits;

    // restoring division, one quotient bit a cycle; quotient bits
    // shift in behind the dividend bits
    assign trial = {rem_reg, dvd_reg[QUO_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(QUO_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= dividend[CR2_W-1:QUO_W];
            dvd_reg <= dividend[QUO_W-1:0];
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? LSQ_W'(trial - {1'b0, dsr_reg}) : trial[LSQ_W-1:0];
            dvd_reg <= {dvd_reg[QUO_W-2:0], fits};
        end
    end

    assign busy = busy_reg;
    assign quot = dvd_reg;

endmodule

// ----- rtl/core/ppd_sqrt.sv -----
module ppd_sqrt
    import ppd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [RAD_W-1:0]  rad,
    output logic              busy,
    output logic [ROOT_W-1:0] root
);

    localparam int CNT_W = $clog2(ROOT_W + 1);
    localparam int REM_W = ROOT_W + 2;

    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  cand;
    logic              fits;

    // digit by digit, two radicand bits per step
    assign trial = {rem_reg, rad_reg[RAD_W-1:RAD_W-2]};
    assign cand  = {2'b00, root_reg, 2'b01};
    assign fits  = trial >= cand;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(ROOT_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= rad;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= fits ? REM_W'(trial - cand) : trial[REM_W-1:0];
            root_reg <= {root_reg[ROOT_W-2:0], fits};
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

// ----- rtl/core/ppd_dp.sv -----
module ppd_dp
    import ppd_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic              aclk,
    input  logic              aresetn,
    input  op_t               op,
    output dp_status_t        status,
    input  logic [63:0]       s_tdata,
    input  logic              s_tlast,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_wdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DST_W-1:0]  m_distance,
    output logic              m_inside
);

    // squared length of 0.000001 in raw units
    localparam logic [LSQ_W-1:0] EPS_RAW =
        LSQ_W'((64'd1 << (2 * FRAC_BITS)) / 64'd1000000);

    logic [VTX_W-1:0] qx_reg, qy_reg;
    logic [SW_W-1:0]  sw_reg;
    logic [VTX_W-1:0] first_x_reg, first_y_reg, prev_x_reg, prev_y_reg;
    logic [VTX_W-1:0] cur_x_reg, cur_y_reg;
    logic             last_reg, have_first_reg, parity_reg;
    logic [DST_W-1:0] best_reg, dist_reg;
    logic             out_valid_reg, out_inside_reg;
    logic [DST_W-1:0] out_dist_reg;

    logic signed [DIFF_W-1:0] v1x_reg, v1y_reg, v2x_reg, v2y_reg, v3x_reg, v3y_reg;
    logic             xing_reg, dy_pos_reg;

    logic [PRD_W-1:0] prod_reg;
    logic             neg_reg;
    op_t              acc_op_reg;
    logic [LSQ_W-1:0] lensq_reg, sq_reg;
    logic [DOT_W-1:0] dot_reg, cross_reg;
    logic [CR2_W-1:0] cr2_reg;

    // edge endpoints chosen by the setup op
    logic signed [DIFF_W-1:0] sx, sy, ex, ey, qx, qy;
    logic [MAG_W-1:0] mag_a, mag_b;
    logic             mneg;
    logic [DOT_W-1:0] pz, sp, cneg;
    logic [LSQ_W-1:0] cmag;
    logic             cross_pos, cross_neg;

    logic             div_busy, sqrt_busy, sqrt_start;
    logic [QUO_W-1:0] quot;
    logic [RAD_W-1:0] rad;
    logic [ROOT_W-1:0] root;
    logic [ROOT_W-1:0] half, diff;

    function automatic logic [MAG_W-1:0] abs_d(input logic signed [DIFF_W-1:0] v);
        logic [DIFF_W-1:0] t;
        t = v[DIFF_W-1] ? (~v + DIFF_W'(1)) : v;
        return t[MAG_W-1:0];
    endfunction

    always_comb begin
        qx = {qx_reg[VTX_W-1], qx_reg};
        qy = {qy_reg[VTX_W-1], qy_reg};
        if (op == OP_SETUP_CLOSE) begin
            sx = {cur_x_reg[VTX_W-1], cur_x_reg};
            sy = {cur_y_reg[VTX_W-1], cur_y_reg};
            ex = {first_x_reg[VTX_W-1], first_x_reg};
            ey = {first_y_reg[VTX_W-1], first_y_reg};
        end else begin
            sx = {prev_x_reg[VTX_W-1], prev_x_reg};
            sy = {prev_y_reg[VTX_W-1], prev_y_reg};
            ex = {cur_x_reg[VTX_W-1], cur_x_reg};
            ey = {cur_y_reg[VTX_W-1], cur_y_reg};
        end
    end

    assign cneg      = ~cross_reg + DOT_W'(1);
    assign cmag      = cross_reg[DOT_W-1] ? cneg[LSQ_W-1:0] : cross_reg[LSQ_W-1:0];
    assign cross_neg = cross_reg[DOT_W-1];
    assign cross_pos = !cross_reg[DOT_W-1] && (cross_reg != '0);

    // operand select for the shared 32x32 multiplier
    always_comb begin
        mag_a = '0;
        mag_b = '0;
        mneg  = 1'b0;
        unique case (op)
            OP_LEN_X: begin
                mag_a = abs_d(v1x_reg); mag_b = abs_d(v1x_reg);
            end
            OP_LEN_Y: begin
                mag_a = abs_d(v1y_reg); mag_b = abs_d(v1y_reg);
            end
            OP_DOT_X: begin
                mag_a = abs_d(v1x_reg); mag_b = abs_d(v2x_reg);
                mneg  = v1x_reg[DIFF_W-1] ^ v2x_reg[DIFF_W-1];
            end
            OP_DOT_Y: begin
                mag_a = abs_d(v1y_reg); mag_b = abs_d(v2y_reg);
                mneg  = v1y_reg[DIFF_W-1] ^ v2y_reg[DIFF_W-1];
            end
            OP_CRS_A: begin
                mag_a = abs_d(v1x_reg); mag_b = abs_d(v2y_reg);
                mneg  = v1x_reg[DIFF_W-1] ^ v2y_reg[DIFF_W-1];
            end
            OP_CRS_B: begin
                mag_a = abs_d(v1y_reg); mag_b = abs_d(v2x_reg);
                mneg  = v1y_reg[DIFF_W-1] ^ v2x_reg[DIFF_W-1];
            end
            OP_W2_X: begin
                mag_a = abs_d(v2x_reg); mag_b = abs_d(v2x_reg);
            end
            OP_W2_Y: begin
                mag_a = abs_d(v2y_reg); mag_b = abs_d(v2y_reg);
            end
            OP_W3_X: begin
                mag_a = abs_d(v3x_reg); mag_b = abs_d(v3x_reg);
            end
            OP_W3_Y: begin
                mag_a = abs_d(v3y_reg); mag_b = abs_d(v3y_reg);
            end
            OP_CR2_LO: begin
                mag_a = cmag[31:0]; mag_b = cmag[31:0];
            end
            OP_CR2_MID: begin
                mag_a = cmag[31:0]; mag_b = cmag[63:32];
            end
            OP_CR2_TOP: begin
                mag_a = cmag[63:32]; mag_b = cmag[63:32];
            end
            default: ;
        endcase
    end

    assign pz = {2'b00, prod_reg};
    assign sp = neg_reg ? (~pz + DOT_W'(1)) : pz;

    assign half = {3'b000, sw_reg[SW_W-1:1]};
    assign diff = root - half;

    always_ff @(posedge aclk) begin
        prod_reg <= mag_a * mag_b;
        neg_reg  <= mneg;

        unique case (op)
            OP_LOAD: begin
                cur_x_reg <= s_tdata[31:0];
                cur_y_reg <= s_tdata[63:32];
                last_reg  <= s_tlast;
                if (!have_first_reg) begin
                    first_x_reg <= s_tdata[31:0];
                    first_y_reg <= s_tdata[63:32];
                    prev_x_reg  <= s_tdata[31:0];
                    prev_y_reg  <= s_tdata[63:32];
                end
            end
            OP_SETUP_OPEN, OP_SETUP_CLOSE: begin
                v1x_reg    <= ex - sx;
                v1y_reg    <= ey - sy;
                v2x_reg    <= qx - sx;
                v2y_reg    <= qy - sy;
                v3x_reg    <= qx - ex;
                v3y_reg    <= qy - ey;
                // half-open rule on y
                xing_reg   <= ((sy <= qy) && (ey > qy)) || ((sy > qy) && (ey <= qy));
                dy_pos_reg <= ey > sy;
                if (op == OP_SETUP_OPEN) begin
                    prev_x_reg <= cur_x_reg;
                    prev_y_reg <= cur_y_reg;
                end
            end
            OP_LEN_DONE: dist_reg <= root[DST_W-1:0];
            OP_LEN_SAT:  dist_reg <= '1;
            OP_PERP_DONE: begin
                if (root <= half) begin
                    dist_reg <= '0;
                end else begin
                    dist_reg <= diff[ROOT_W-1] ? '1 : diff[DST_W-1:0];
                end
            end
            OP_EMIT: begin
                out_dist_reg   <= parity_reg ? '0 : best_reg;
                out_inside_reg <= parity_reg;
            end
            default: ;
        endcase

        // accumulate stage, in the cycle after the multiply
        unique case (acc_op_reg) inside
            OP_LEN_X:            lensq_reg <= LSQ_W'(prod_reg);
            OP_LEN_Y:            lensq_reg <= lensq_reg + LSQ_W'(prod_reg);
            OP_DOT_X:            dot_reg   <= sp;
            OP_DOT_Y:            dot_reg   <= dot_reg + sp;
            OP_CRS_A:            cross_reg <= sp;
            OP_CRS_B:            cross_reg <= cross_reg - sp;
            OP_W2_X, OP_W3_X:    sq_reg    <= LSQ_W'(prod_reg);
            OP_W2_Y, OP_W3_Y:    sq_reg    <= sq_reg + LSQ_W'(prod_reg);
            OP_CR2_LO:  cr2_reg <= {1'b0, cmag[LSQ_W-1], 64'b0, prod_reg};
            OP_CR2_MID: cr2_reg <= cr2_reg + {33'b0, prod_reg, 33'b0};
            OP_CR2_TOP: cr2_reg <= cr2_reg + {2'b0, prod_reg, 64'b0};
            OP_CR2_HI: begin
                // top bit of |cross|: adds 2^128 (set above) and c[63:0] << 65
                if (cmag[LSQ_W-1]) begin
                    cr2_reg <= cr2_reg + {1'b0, cmag[63:0], 65'b0};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qx_reg         <= '0;
            qy_reg         <= '0;
            sw_reg         <= '0;
            have_first_reg <= 1'b0;
            parity_reg     <= 1'b0;
            best_reg       <= '1;
            out_valid_reg  <= 1'b0;
            acc_op_reg     <= OP_NOP;
        end else begin
            acc_op_reg <= op;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_QUERY_X:      qx_reg <= cfg_wdata;
                    REG_QUERY_Y:      qy_reg <= cfg_wdata;
                    REG_STROKE_WIDTH: sw_reg <= cfg_wdata[SW_W-1:0];
                    default: ;
                endcase
            end
            if (op == OP_EMIT) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (op)
                OP_LOAD: have_first_reg <= 1'b1;
                OP_UPDATE: begin
                    parity_reg <= parity_reg ^
                                  (xing_reg & (dy_pos_reg ? cross_pos : cross_neg));
                    if (dist_reg < best_reg) begin
                        best_reg <= dist_reg;
                    end
                end
                OP_EMIT: begin
                    have_first_reg <= 1'b0;
                    parity_reg     <= 1'b0;
                    best_reg       <= '1;
                end
                default: ;
            endcase
        end
    end

    assign sqrt_start = (op == OP_SQRT_W) || (op == OP_SQRT_P);
    assign rad        = (op == OP_SQRT_P) ? {1'b0, quot} : {1'b0, sq_reg};

    ppd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (op == OP_DIV),
        .dividend (cr2_reg),
        .divisor  (lensq_reg),
        .busy     (div_busy),
        .quot     (quot)
    );

    ppd_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_start),
        .rad     (rad),
        .busy    (sqrt_busy),
        .root    (root)
    );

    always_comb begin
        status.have_first = have_first_reg;
        status.last       = last_reg;
        status.busy       = div_busy | sqrt_busy;
        status.degen      = lensq_reg <= EPS_RAW;
        status.pre_start  = dot_reg[DOT_W-1];
        status.past       = $signed(dot_reg) > $signed({1'b0, lensq_reg});
        status.sq_ovf     = sq_reg[LSQ_W-1];
        status.out_free   = !out_valid_reg || m_tready;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_distance = out_dist_reg;
    assign m_inside   = out_inside_reg;

endmodule

// ----- rtl/core/ppd_ctrl.sv -----
module ppd_ctrl
    import ppd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output op_t        op
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_OPEN  = 5'd1;
    localparam logic [4:0] S_CHK   = 5'd2;
    localparam logic [4:0] S_CLOSE = 5'd3;
    localparam logic [4:0] S_LX    = 5'd4;
    localparam logic [4:0] S_LY    = 5'd5;
    localparam logic [4:0] S_DX    = 5'd6;
    localparam logic [4:0] S_DY    = 5'd7;
    localparam logic [4:0] S_CA    = 5'd8;
    localparam logic [4:0] S_CB    = 5'd9;
    localparam logic [4:0] S_CLSW  = 5'd10;
    localparam logic [4:0] S_CLS   = 5'd11;
    localparam logic [4:0] S_W2X   = 5'd12;
    localparam logic [4:0] S_W2Y   = 5'd13;
    localparam logic [4:0] S_W3X   = 5'd14;
    localparam logic [4:0] S_W3Y   = 5'd15;
    localparam logic [4:0] S_SQWW  = 5'd16;
    localparam logic [4:0] S_SQW   = 5'd17;
    localparam logic [4:0] S_SQWR  = 5'd18;
    localparam logic [4:0] S_LEND  = 5'd19;
    localparam logic [4:0] S_C0    = 5'd20;
    localparam logic [4:0] S_C1    = 5'd21;
    localparam logic [4:0] S_C2    = 5'd22;
    localparam logic [4:0] S_C3    = 5'd23;
    localparam logic [4:0] S_DIVW  = 5'd24;
    localparam logic [4:0] S_DIV   = 5'd25;
    localparam logic [4:0] S_DIVR  = 5'd26;
    localparam logic [4:0] S_SQP   = 5'd27;
    localparam logic [4:0] S_SQPR  = 5'd28;
    localparam logic [4:0] S_PERP  = 5'd29;
    localparam logic [4:0] S_UPD   = 5'd30;
    localparam logic [4:0] S_EMIT  = 5'd31;

    logic [4:0] state_reg, state_next;
    logic       closing_reg, closing_next;

    always_comb begin
        state_next   = state_reg;
        closing_next = closing_reg;
        op           = OP_NOP;
        s_tready     = state_reg == S_IDLE;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op         = OP_LOAD;
                    state_next = status.have_first ? S_OPEN : S_CHK;
                end
            end
            S_OPEN: begin
                op           = OP_SETUP_OPEN;
                closing_next = 1'b0;
                state_next   = S_LX;
            end
            S_CHK:   state_next = status.last ? S_CLOSE : S_IDLE;
            S_CLOSE: begin
                op           = OP_SETUP_CLOSE;
                closing_next = 1'b1;
                state_next   = S_LX;
            end
            S_LX: begin op = OP_LEN_X; state_next = S_LY; end
            S_LY: begin op = OP_LEN_Y; state_next = S_DX; end
            S_DX: begin op = OP_DOT_X; state_next = S_DY; end
            S_DY: begin op = OP_DOT_Y; state_next = S_CA; end
            S_CA: begin op = OP_CRS_A; state_next = S_CB; end
            S_CB: begin op = OP_CRS_B; state_next = S_CLSW; end
            S_CLSW: state_next = S_CLS;
            S_CLS: begin
                if (status.degen || status.pre_start) begin
                    state_next = S_W2X;
                end else if (status.past) begin
                    state_next = S_W3X;
                end else begin
                    state_next = S_C0;
                end
            end
            S_W2X: begin op = OP_W2_X; state_next = S_W2Y; end
            S_W2Y: begin op = OP_W2_Y; state_next = S_SQWW; end
            S_W3X: begin op = OP_W3_X; state_next = S_W3Y; end
            S_W3Y: begin op = OP_W3_Y; state_next = S_SQWW; end
            S_SQWW: state_next = S_SQW;
            S_SQW: begin
                if (status.sq_ovf) begin
                    op         = OP_LEN_SAT;
                    state_next = S_UPD;
                end else begin
                    op         = OP_SQRT_W;
                    state_next = S_SQWR;
                end
            end
            S_SQWR: if (!status.busy) state_next = S_LEND;
            S_LEND: begin op = OP_LEN_DONE; state_next = S_UPD; end
            S_C0: begin op = OP_CR2_LO;  state_next = S_C1; end
            S_C1: begin op = OP_CR2_MID; state_next = S_C2; end
            S_C2: begin op = OP_CR2_TOP; state_next = S_C3; end
            S_C3: begin op = OP_CR2_HI;  state_next = S_DIVW; end
            S_DIVW: state_next = S_DIV;
            S_DIV:  begin op = OP_DIV; state_next = S_DIVR; end
            S_DIVR: if (!status.busy) state_next = S_SQP;
            S_SQP:  begin op = OP_SQRT_P; state_next = S_SQPR; end
            S_SQPR: if (!status.busy) state_next = S_PERP;
            S_PERP: begin op = OP_PERP_DONE; state_next = S_UPD; end
            S_UPD: begin
                op = OP_UPDATE;
                if (closing_reg) begin
                    state_next = S_EMIT;
                end else begin
                    state_next = status.last ? S_CLOSE : S_IDLE;
                end
            end
            S_EMIT: begin
                if (status.out_free) begin
                    op         = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            closing_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            closing_reg <= closing_next;
        end
    end

`ifndef SYNTHESIS
    a_ready_units_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !status.busy)
        else $error("input ready while an iterative unit runs");
    a_div_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (op == OP_DIV) |=> status.busy)
        else $error("divider did not start");
    a_sqrt_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (op == OP_SQRT_W || op == OP_SQRT_P) |=> status.busy)
        else $error("root unit did not start");
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (op == OP_EMIT) |-> status.out_free)
        else $error("result written over a pending word");
`endif

endmodule
